// ===== rtl/btt_pkg.sv =====
// Shared types and constants for the bounded score transposition table.
// Used by every module of the block except btt_ram; depends on nothing.
`default_nettype none

package btt_pkg;

  localparam int SLOT_BITS   = 12;
  localparam int TABLE_SLOTS = 1 << SLOT_BITS;

  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 7;
  localparam int SCORE_W = 16;
  localparam int MOVE_W  = 16;
  localparam int BOUND_W = 2;

  // Input tdata layout, lowest bit first.
  localparam int IN_KEY_LSB   = 0;
  localparam int IN_DEPTH_LSB = IN_KEY_LSB + KEY_W;
  localparam int IN_SCORE_LSB = IN_DEPTH_LSB + DEPTH_W;
  localparam int IN_MOVE_LSB  = IN_SCORE_LSB + SCORE_W;
  localparam int IN_BOUND_LSB = IN_MOVE_LSB + MOVE_W;
  localparam int IN_WLOW_LSB  = IN_BOUND_LSB + BOUND_W;
  localparam int IN_WHIGH_LSB = IN_WLOW_LSB + SCORE_W;
  localparam int IN_USED_W    = IN_WHIGH_LSB + SCORE_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_TDATA_W = SCORE_W + MOVE_W;
  localparam int OUT_TUSER_W = 2;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_PROBE = 1'b1;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [BOUND_W-1:0]  bound;
    logic [MOVE_W-1:0]   move;
    logic [DEPTH_W-1:0]  depth;
    logic [SCORE_W-1:0]  score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic tbl_write;
    logic tbl_read;
    logic req_load;
    logic res_store;
    logic res_probe;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/bounded_score_transposition_table_core.sv =====
// Top level of the bounded score transposition table.
// Depends on btt_pkg, btt_ctrl, btt_dpath and btt_ram.
//
// Channel | Direction | tdata (lowest bit first)                         | tuser
// in_     | input     | key, depth, score, move, bound, win low, win high | cmd
// out_    | output    | found_score, found_move                           | usable, found
//
// After reset the table runs a clearing pass over all 4096 slots, one slot a cycle.
// A store writes its slot on acceptance and its result is registered the next cycle.
// A probe takes two steps: a RAM read on acceptance, then a compare in ST_LOOKUP.
// A stalled output holds its result and blocks new transactions.
// Reset is synchronous and active low.
`default_nettype none

module bounded_score_transposition_table_core
  import btt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // position_key, search_depth, entry_score, entry_move, bound_kind,
  // window_low, window_high, zero padding.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd.
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // found_score, found_move.
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // score_usable, key_found.
  output logic      [OUT_TUSER_W-1:0] out_tuser
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  btt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  btt_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_tdata (in_tdata),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/btt_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module btt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/btt_dpath.sv =====
// Datapath: clear counter, slot RAM, probe request registers, hit and bound
// check, and the result register. Depends on btt_pkg and btt_ram.
`default_nettype none

module btt_dpath
  import btt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ctrl_cmd_t              cmd,
  output dp_status_t                  status,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic      [OUT_TUSER_W-1:0] out_tuser
);

  logic [SLOT_BITS-1:0]   clr_addr_r, clr_addr_nxt;
  logic [KEY_W-1:0]       req_key_r;
  logic [DEPTH_W-1:0]     req_depth_r;
  logic signed [SCORE_W-1:0] req_wlow_r, req_whigh_r;
  logic [OUT_TDATA_W-1:0] res_data_r, res_data_nxt;
  logic [OUT_TUSER_W-1:0] res_user_r, res_user_nxt;

  logic [KEY_W-1:0]       in_key;
  entry_t                 in_entry;
  logic [SLOT_BITS-1:0]   ram_addr;
  entry_t                 ram_wdata;
  entry_t                 ram_rdata;
  logic signed [SCORE_W-1:0] stored_score;
  logic                   hit;
  logic                   depth_ok;
  logic                   bound_ok;
  logic                   usable;

  assign in_key = in_tdata[IN_KEY_LSB +: KEY_W];

  always_comb begin
    in_entry.valid = 1'b1;
    in_entry.key   = in_key;
    in_entry.bound = in_tdata[IN_BOUND_LSB +: BOUND_W];
    in_entry.move  = in_tdata[IN_MOVE_LSB +: MOVE_W];
    in_entry.depth = in_tdata[IN_DEPTH_LSB +: DEPTH_W];
    in_entry.score = in_tdata[IN_SCORE_LSB +: SCORE_W];
  end

  assign ram_addr  = cmd.clr_step ? clr_addr_r : in_key[SLOT_BITS-1:0];
  assign ram_wdata = cmd.clr_step ? entry_t'('0) : in_entry;

  btt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (cmd.tbl_write),
    .re   (cmd.tbl_read),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign clr_addr_nxt    = clr_addr_r + SLOT_BITS'(1);
  assign status.clr_last = (clr_addr_r == {SLOT_BITS{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_key_r   <= in_key;
      req_depth_r <= in_tdata[IN_DEPTH_LSB +: DEPTH_W];
      req_wlow_r  <= in_tdata[IN_WLOW_LSB +: SCORE_W];
      req_whigh_r <= in_tdata[IN_WHIGH_LSB +: SCORE_W];
    end
  end

  assign stored_score = ram_rdata.score;
  assign hit      = ram_rdata.valid && (ram_rdata.key == req_key_r);
  assign depth_ok = (ram_rdata.depth >= req_depth_r);

  always_comb begin
    case (ram_rdata.bound)
      BOUND_EXACT: bound_ok = 1'b1;
      BOUND_LOWER: bound_ok = (stored_score >= req_whigh_r);
      BOUND_UPPER: bound_ok = (stored_score <= req_wlow_r);
      default:     bound_ok = 1'b0;
    endcase
  end

  assign usable = hit && depth_ok && bound_ok;

  always_comb begin
    res_data_nxt = res_data_r;
    res_user_nxt = res_user_r;
    if (cmd.res_store) begin
      res_data_nxt = '0;
      res_user_nxt = '0;
    end else if (cmd.res_probe) begin
      res_data_nxt = {(hit ? ram_rdata.move : MOVE_W'(0)),
                      (usable ? ram_rdata.score : SCORE_W'(0))};
      res_user_nxt = {hit, usable};
    end
  end

  always_ff @(posedge clk) begin
    res_data_r <= res_data_nxt;
    res_user_r <= res_user_nxt;
  end

  assign out_tdata = res_data_r;
  assign out_tuser = res_user_r;

endmodule

`default_nettype wire

// ===== rtl/btt_ctrl.sv =====
// Controller state machine: clearing pass, command acceptance, probe lookup
// and result valid. Depends on btt_pkg.
`default_nettype none

module btt_ctrl
  import btt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic       in_cmd,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_fire;

  assign out_free = !out_valid_r || out_tready;
  assign in_fire  = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step  = 1'b1;
        cmd.tbl_write = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = out_free;
        if (in_fire) begin
          if (in_cmd == CMD_STORE) begin
            cmd.tbl_write = 1'b1;
            cmd.res_store = 1'b1;
          end else begin
            cmd.tbl_read = 1'b1;
            cmd.req_load = 1'b1;
            state_nxt    = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          cmd.res_probe = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_store || cmd.res_probe) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("Input accepted during the clearing pass.");

  a_probe_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == CMD_PROBE) |=> (state_r == ST_LOOKUP))
    else $error("Probe transaction did not start a lookup.");

  a_store_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == CMD_STORE) |=> out_tvalid)
    else $error("Store transaction produced no result.");

  a_lookup_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP && out_free) |=> (out_tvalid && state_r == ST_IDLE))
    else $error("Lookup did not deliver its result.");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.res_store && cmd.res_probe))
    else $error("Two results loaded in one cycle.");
`endif

endmodule

`default_nettype wire
